### design/fa2b_pkg.sv
// ---------------------------------------------------------------------------
// fa2b_pkg: shared types and constants for the FASTA 2-bit packer
// Result kinds, parse modes, character codes, the command record that the
// parser hands to the emitter, and the LFSR step function.
// ---------------------------------------------------------------------------
package fa2b_pkg;

    // Result kinds as seen on the result channel.
    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;
    localparam logic [1:0] KIND_PAD   = 2'd3;

    // Parser modes; unused codes behave as skip.
    localparam logic [2:0] MODE_SKIP = 3'd0;
    localparam logic [2:0] MODE_GT   = 3'd1;
    localparam logic [2:0] MODE_GTN  = 3'd2;
    localparam logic [2:0] MODE_NAME = 3'd3;
    localparam logic [2:0] MODE_SEQ  = 3'd4;

    // Character codes.
    localparam logic [7:0] CHR_EOF = 8'h00;
    localparam logic [7:0] CHR_LF  = 8'h0A;
    localparam logic [7:0] CHR_GT  = 8'h3E;
    localparam logic [7:0] CHR_N   = 8'h4E;
    localparam logic [7:0] CHR_C   = 8'h43;

    // Nucleotide letters and the raw byte codes that stand for C, G and T.
    localparam logic [7:0] CHR_A  = 8'h41;
    localparam logic [7:0] CHR_G  = 8'h47;
    localparam logic [7:0] CHR_T  = 8'h54;
    localparam logic [7:0] CHR_LA = 8'h61;
    localparam logic [7:0] CHR_LC = 8'h63;
    localparam logic [7:0] CHR_LG = 8'h67;
    localparam logic [7:0] CHR_LT = 8'h74;
    localparam logic [7:0] RAW_C  = 8'h01;
    localparam logic [7:0] RAW_G  = 8'h02;
    localparam logic [7:0] RAW_T  = 8'h03;

    // Two-bit nucleotide codes.
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Everything one input byte produces, in emission order:
    // count, name bytes, word, T-filled words, padded length.
    typedef struct packed {
        logic        cnt_vld;
        logic [31:0] cnt_val;
        logic [1:0]  name_cnt;
        logic [7:0]  name_byte;
        logic        wrd_vld;
        logic [31:0] wrd_val;
        logic [2:0]  fill_cnt;
        logic        pad_vld;
        logic [31:0] pad_val;
    } cmd_t;

    // One step of the right-shifting Galois LFSR; the output bit is s[0].
    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] r;
        r = s >> 1;
        if (s[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

### design/fa2b_front.sv
// ---------------------------------------------------------------------------
// fa2b_front: byte parser and nucleotide packer
// Tracks the header state, packs 2-bit codes, keeps the counts and the LFSR,
// and turns each accepted byte into at most one command for the emitter.
// ---------------------------------------------------------------------------
module fa2b_front
    import fa2b_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    output logic        push,
    output cmd_t        cmd
);

    logic [2:0]  mode_reg, mode_next;
    logic [31:0] buf_reg, buf_next;
    logic [3:0]  codes_reg, codes_next;
    logic [31:0] rec_reg, rec_next;
    logic [31:0] tot_reg, tot_next;
    logic [15:0] lfsr_reg, lfsr_next;
    logic [15:0] seed_reg;

    logic [15:0] lfsr_one, lfsr_two;
    logic [1:0]  code;
    logic        code_rand;
    logic [31:0] packed_word;
    logic [3:0]  rest;
    logic [4:0]  shamt;
    logic [31:0] fill_word;
    logic [1:0]  quarter;
    logic [31:0] padded;
    logic [31:0] rec_inc, tot_inc;

    // Nucleotide code; other bytes draw two bits from the LFSR.
    always_comb begin
        lfsr_one  = lfsr_step(lfsr_reg);
        lfsr_two  = lfsr_step(lfsr_one);
        code_rand = 1'b0;
        case (in_byte)
            CHR_A, CHR_LA:        code = CODE_A;
            CHR_C, CHR_LC, RAW_C: code = CODE_C;
            CHR_G, CHR_LG, RAW_G: code = CODE_G;
            CHR_T, CHR_LT, RAW_T: code = CODE_T;
            default: begin
                code      = {lfsr_one[0], lfsr_reg[0]};
                code_rand = 1'b1;
            end
        endcase
    end

    // End-of-file arithmetic: T-filled partial word and padded length.
    always_comb begin
        packed_word = {buf_reg[29:0], code};
        rest        = 4'd0 - codes_reg;
        shamt       = {rest, 1'b0};
        fill_word   = (buf_reg << shamt) | ~(WORD_ONES << shamt);
        quarter     = tot_reg[5:4];
        if (&tot_reg[31:6]) begin
            padded = WORD_ONES;
        end else begin
            padded = {tot_reg[31:6] + 26'd1, 6'd0};
        end
        rec_inc = (rec_reg == WORD_ONES) ? rec_reg : rec_reg + 32'd1;
        tot_inc = (tot_reg == WORD_ONES) ? tot_reg : tot_reg + 32'd1;
    end

    // Parser next state and command.
    always_comb begin
        mode_next  = mode_reg;
        buf_next   = buf_reg;
        codes_next = codes_reg;
        rec_next   = rec_reg;
        tot_next   = tot_reg;
        lfsr_next  = lfsr_reg;
        cmd        = '0;
        if (in_byte == CHR_EOF) begin
            cmd.cnt_vld = (rec_reg != 32'd0);
            cmd.cnt_val = rec_reg;
            if (codes_reg != 4'd0) begin
                cmd.wrd_vld  = 1'b1;
                cmd.wrd_val  = fill_word;
                cmd.fill_cnt = 3'd3 - {1'b0, quarter};
            end else begin
                cmd.fill_cnt = 3'd4 - {1'b0, quarter};
            end
            cmd.pad_vld = 1'b1;
            cmd.pad_val = padded;
            mode_next   = MODE_SKIP;
            buf_next    = 32'd0;
            codes_next  = 4'd0;
            rec_next    = 32'd0;
            tot_next    = 32'd0;
            lfsr_next   = seed_reg;
        end else if (in_byte == CHR_GT) begin
            cmd.cnt_vld = (rec_reg != 32'd0);
            cmd.cnt_val = rec_reg;
            rec_next    = 32'd0;
            mode_next   = MODE_GT;
        end else begin
            case (mode_reg)
                MODE_GT: begin
                    mode_next = (in_byte == CHR_N) ? MODE_GTN : MODE_SKIP;
                end
                MODE_GTN: begin
                    if (in_byte == CHR_C) begin
                        cmd.name_cnt  = 2'd2;
                        cmd.name_byte = CHR_C;
                        mode_next     = MODE_NAME;
                    end else begin
                        mode_next = MODE_SKIP;
                    end
                end
                MODE_NAME: begin
                    if (in_byte == CHR_LF) begin
                        mode_next = MODE_SEQ;
                    end else begin
                        cmd.name_cnt  = 2'd1;
                        cmd.name_byte = in_byte;
                    end
                end
                MODE_SEQ: begin
                    if (in_byte != CHR_LF) begin
                        rec_next = rec_inc;
                        tot_next = tot_inc;
                        if (code_rand) begin
                            lfsr_next = lfsr_two;
                        end
                        if (codes_reg == 4'd15) begin
                            cmd.wrd_vld = 1'b1;
                            cmd.wrd_val = packed_word;
                            buf_next    = 32'd0;
                            codes_next  = 4'd0;
                        end else begin
                            buf_next   = packed_word;
                            codes_next = codes_reg + 4'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign push = accept &&
                  (cmd.cnt_vld || cmd.name_cnt != 2'd0 || cmd.wrd_vld || cmd.pad_vld);

    // State registers; a seed write reloads the LFSR at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_SKIP;
            buf_reg   <= 32'd0;
            codes_reg <= 4'd0;
            rec_reg   <= 32'd0;
            tot_reg   <= 32'd0;
            lfsr_reg  <= 16'd1;
            seed_reg  <= 16'd1;
        end else begin
            if (accept) begin
                mode_reg  <= mode_next;
                buf_reg   <= buf_next;
                codes_reg <= codes_next;
                rec_reg   <= rec_next;
                tot_reg   <= tot_next;
                lfsr_reg  <= lfsr_next;
            end
            if (cfg_we) begin
                seed_reg <= cfg_wdata;
                lfsr_reg <= cfg_wdata;
            end
        end
    end

endmodule

### design/fa2b_queue.sv
// ---------------------------------------------------------------------------
// fa2b_queue: command queue between parser and emitter
// A small register FIFO so that the parser keeps taking bytes while the
// emitter works through a multi-result command or waits on the receiver.
// ---------------------------------------------------------------------------
module fa2b_queue
    import fa2b_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_vld,
    output cmd_t head_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign head_vld = (cnt_reg != '0);
    assign head_cmd = mem[rd_ptr_reg];
    assign do_pop   = pop && head_vld;

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // The parser must never write into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("command queue overflow");

endmodule

### design/fa2b_back.sv
// ---------------------------------------------------------------------------
// fa2b_back: result emitter
// Takes commands from the queue and sends their result items one per cycle
// while m_ready allows, via the output register, flagging the last of each.
// ---------------------------------------------------------------------------
module fa2b_back
    import fa2b_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_vld,
    input  cmd_t        head_cmd,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_payload,
    output logic        m_last
);

    cmd_t        cur_reg, after;
    logic        cur_vld_reg;
    logic        out_vld_reg;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_payload_reg;
    logic        out_last_reg;
    logic [1:0]  item_kind;
    logic [31:0] item_payload;
    logic        done, emit, out_free, take;

    // Pick the next pending result of the current command.
    always_comb begin
        after = cur_reg;
        if (cur_reg.cnt_vld) begin
            item_kind     = KIND_COUNT;
            item_payload  = cur_reg.cnt_val;
            after.cnt_vld = 1'b0;
        end else if (cur_reg.name_cnt != 2'd0) begin
            item_kind      = KIND_NAME;
            item_payload   = (cur_reg.name_cnt == 2'd2) ? {24'd0, CHR_N}
                                                        : {24'd0, cur_reg.name_byte};
            after.name_cnt = cur_reg.name_cnt - 2'd1;
        end else if (cur_reg.wrd_vld) begin
            item_kind     = KIND_WORD;
            item_payload  = cur_reg.wrd_val;
            after.wrd_vld = 1'b0;
        end else if (cur_reg.fill_cnt != 3'd0) begin
            item_kind      = KIND_WORD;
            item_payload   = WORD_ONES;
            after.fill_cnt = cur_reg.fill_cnt - 3'd1;
        end else begin
            item_kind     = KIND_PAD;
            item_payload  = cur_reg.pad_val;
            after.pad_vld = 1'b0;
        end
        done = !(after.cnt_vld || after.name_cnt != 2'd0 || after.wrd_vld ||
                 after.fill_cnt != 3'd0 || after.pad_vld);
    end

    assign out_free = !out_vld_reg || m_ready;
    assign emit     = cur_vld_reg && out_free;
    assign take     = !cur_vld_reg || (emit && done);
    assign pop      = take && head_vld;

    // Current command register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_vld_reg <= 1'b0;
        end else if (take) begin
            cur_vld_reg <= head_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cur_reg <= head_cmd;
        end else if (emit) begin
            cur_reg <= after;
        end
    end

    // Output register; it holds its item while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_kind_reg    <= item_kind;
            out_payload_reg <= item_payload;
            out_last_reg    <= done;
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_kind    = out_kind_reg;
    assign m_payload = out_payload_reg;
    assign m_last    = out_last_reg;

    // A command held here always has at least one result left.
    a_cmd_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_vld_reg |-> (cur_reg.cnt_vld || cur_reg.name_cnt != 2'd0 ||
                         cur_reg.wrd_vld || cur_reg.fill_cnt != 3'd0 || cur_reg.pad_vld))
        else $error("empty command in emitter");

    // The padded length always closes its command.
    a_pad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && out_kind_reg == KIND_PAD) |-> out_last_reg)
        else $error("padded length not flagged last");

    // An emitted item that is not last keeps a command in the emitter.
    a_more_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !done) |=> cur_vld_reg)
        else $error("command dropped before its last item");

endmodule

### design/fasta_to_2bit_packer.sv
// ---------------------------------------------------------------------------
// fasta_to_2bit_packer: FASTA byte stream to packed 2-bit nucleotide words
// Keeps records whose header starts ">NC", emits their names, counts and
// 16-code words, and pads the stream to a multiple of 64 codes at file end.
// ---------------------------------------------------------------------------
// Usage:
//   Bytes enter on s_valid/s_ready/s_file_byte, zero or more items per byte;
//   a zero byte ends the file. Results leave on m_valid/m_ready with m_kind,
//   m_payload and m_last; m_last marks the final item caused by one byte.
//   cfg_we/cfg_wdata write the LFSR seed, which also reloads the LFSR.
//   The first result of a byte is written to the queue at the edge that
//   accepts it, then passes the command register and the output register.
//   Throughput: one byte per cycle while m_ready is high and each byte
//   yields at most one item. A byte that yields several items (up to six
//   at file end) holds the emitter until all are sent; the command queue
//   absorbs such bursts, and input stalls only when the queue is full.
//   The emitter with its single output register sets the sustained rate of
//   one result item per cycle while m_ready is high.
//   Reset (aresetn low, synchronous) empties the queue and output stage and
//   returns the parser, counts and seed to their initial values.
//   When the receiver stalls, the output item holds, the emitter stops, the
//   queue fills, and s_ready then drops.
// ---------------------------------------------------------------------------
module fasta_to_2bit_packer
    import fa2b_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_file_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_payload,
    output logic        m_last
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic head_vld;
    cmd_t head_cmd;
    logic pop;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Parser: at most one command per accepted byte.
    fa2b_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_file_byte),
        .push      (push),
        .cmd       (push_cmd)
    );

    // Command queue.
    fa2b_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .head_vld (head_vld),
        .head_cmd (head_cmd)
    );

    // Emitter and output register.
    fa2b_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_vld  (head_vld),
        .head_cmd  (head_cmd),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_payload (m_payload),
        .m_last    (m_last)
    );

endmodule
